### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/hbd_pkg.sv
// package for the huffman block decoder: widths, defaults and state encoding
// no dependencies
`default_nettype none
package hbd_pkg;

	localparam int DEF_SYMBOL_COUNT = 256;
	localparam int DEF_TREE_NODES   = 511;
	localparam int NODE_W           = 9;
	localparam int WEIGHT_W         = 32;
	localparam int HPOS_W           = 3;

	typedef enum logic [4:0] {
		ST_COUNT,
		ST_TABLEN,
		ST_ENTRY,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_INS,
		ST_ONE,
		ST_DATA,
		ST_RD,
		ST_NX,
		ST_EMIT,
		ST_STAT,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/huffman_block_decoder_top.sv
// Huffman block decoder: frame header, table, tree build and bit-serial decode.
// Takes one transaction of a coded byte at a time and gives one result per
// symbol (one per run when under two leaves) or status. Header and table
// bytes are accepted without stalling. After the last table entry with two or
// more leaves the tree is built with a sequencer over the order list and
// weight memories: each merge goes through M0 to M3, the insertion scan through
// S0, S1 and S2 per list slot compared (only S0 when the scan reaches the head
// of the list), then the insert INS. In the data phase a byte is accepted in
// DATA, each coded bit takes a child memory read (RD) then a step (NX), and
// every leaf an EMIT for the result load of the symbol read at the step. The
// block stalls input while building or walking and while a result waits on a stalled output register.
`default_nettype none
module huffman_block_decoder_top
	import hbd_pkg::*;
#(
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
	parameter int TREE_NODES   = DEF_TREE_NODES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        coded_valid,
	output logic             coded_stall,
	input  wire logic [7:0]  coded_byte,
	input  wire logic        frame_end,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       symbol,
	output logic [31:0]      repeat_count,
	output logic             run_last,
	output logic             status
);

	localparam int SIW = $clog2(SYMBOL_COUNT);
	localparam int NIW = $clog2(TREE_NODES);
	localparam int LEAF_MAX = (SYMBOL_COUNT < (TREE_NODES + 1) / 2) ?
		SYMBOL_COUNT : (TREE_NODES + 1) / 2;

	state_t state_q, state_n;

	logic [HPOS_W-1:0]   hpos_q;
	logic [31:0]         rem_q;
	logic [NODE_W-1:0]   leaf_cnt_q;
	logic                zero_seen_q;
	logic [NODE_W-1:0]   total_q;
	logic [NODE_W-1:0]   idx_q;
	logic [23:0]         wacc_q;
	logic [7:0]          sym0_q;
	logic                fe_q;
	logic [NODE_W-1:0]   len_q;
	logic [NODE_W-1:0]   next_q;
	logic [NODE_W-1:0]   spos_q;
	logic [NODE_W-1:0]   zero_q;
	logic [NODE_W-1:0]   one_q;
	logic [NODE_W-1:0]   tmp_q;
	logic [WEIGHT_W-1:0] wz_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [NODE_W-1:0]   walk_q;
	logic [NODE_W-1:0]   root_q;
	logic [7:0]          byte_q;
	logic [2:0]          bit_q;
	logic [2:0]          n_q;

	logic [NODE_W-1:0]   list_mem [SYMBOL_COUNT];
	logic [WEIGHT_W-1:0] wt_mem [TREE_NODES];
	logic [2*NODE_W-1:0] ch_mem [SYMBOL_COUNT];
	logic [7:0]          sy_mem [SYMBOL_COUNT];

	logic [NODE_W-1:0]   list_rd;
	logic [WEIGHT_W-1:0] wt_rd;
	logic [2*NODE_W-1:0] ch_rd;
	logic [7:0]          sy_rd;

	logic                list_we, wt_we, ch_we, sy_we;
	logic [NODE_W-1:0]   list_wa, list_ra, list_wd, wt_wa, wt_ra, ch_wa, ch_ra, sy_wa, sy_ra;
	logic [WEIGHT_W-1:0] wt_wd;
	logic [7:0]          sy_wd;

	logic                acc;
	logic                out_ld;
	logic [31:0]         rem_n;
	logic [31:0]         full_w;
	logic                entry_final;
	logic [NODE_W-1:0]   nxt;
	logic                is_leaf;
	logic [WEIGHT_W-1:0] sum_w;

	logic                emit;
	logic [7:0]          e_sym;
	logic [31:0]         e_rep;
	logic                e_last;
	logic                e_st;

	assign acc    = coded_valid && !coded_stall;
	assign out_ld = !result_valid || !result_stall;
	assign full_w = {coded_byte, wacc_q};
	assign entry_final = (hpos_q == HPOS_W'(4)) && ((idx_q + NODE_W'(1)) >= total_q);
	assign nxt     = byte_q[bit_q] ? ch_rd[NODE_W-1:0] : ch_rd[2*NODE_W-1:NODE_W];
	assign is_leaf = nxt < leaf_cnt_q;
	assign sum_w   = wz_q + wt_rd;

	always_comb begin
		rem_n = (hpos_q == '0) ? 32'd0 : rem_q;
		case (hpos_q)
			HPOS_W'(0): rem_n[7:0]   = coded_byte;
			HPOS_W'(1): rem_n[15:8]  = coded_byte;
			HPOS_W'(2): rem_n[23:16] = coded_byte;
			default:    rem_n[31:24] = coded_byte;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_COUNT: begin
				if (acc) begin
					if (hpos_q == HPOS_W'(3) && rem_n == 32'd0) begin
						state_n = frame_end ? ST_COUNT : ST_DRAIN;
					end else if (frame_end) begin
						state_n = ST_STAT;
					end else if (hpos_q == HPOS_W'(3)) begin
						state_n = ST_TABLEN;
					end
				end
			end
			ST_TABLEN: begin
				if (acc) begin
					state_n = frame_end ? ST_STAT : ST_ENTRY;
				end
			end
			ST_ENTRY: begin
				if (acc) begin
					if (entry_final) begin
						state_n = (leaf_cnt_q < NODE_W'(2)) ? ST_ONE : ST_M0;
					end else if (frame_end) begin
						state_n = ST_STAT;
					end
				end
			end
			ST_M0: state_n = ST_M1;
			ST_M1: state_n = ST_M2;
			ST_M2: state_n = ST_M3;
			ST_M3: state_n = ST_S0;
			ST_S0: state_n = (spos_q == '0) ? ST_INS : ST_S1;
			ST_S1: state_n = ST_S2;
			ST_S2: state_n = (wt_rd < w_q) ? ST_S0 : ST_INS;
			ST_INS: begin
				if (len_q > NODE_W'(1)) begin
					state_n = ST_M0;
				end else begin
					state_n = fe_q ? ST_STAT : ST_DATA;
				end
			end
			ST_ONE: begin
				if (out_ld) begin
					state_n = fe_q ? ST_COUNT : ST_DRAIN;
				end
			end
			ST_DATA: begin
				if (acc) begin
					state_n = ST_RD;
				end
			end
			ST_RD: state_n = ST_NX;
			ST_NX: begin
				if (is_leaf) begin
					state_n = ST_EMIT;
				end else if (bit_q == 3'd7) begin
					state_n = fe_q ? ST_STAT : ST_DATA;
				end else begin
					state_n = ST_RD;
				end
			end
			ST_EMIT: begin
				if (out_ld) begin
					if (rem_q == 32'd0) begin
						state_n = fe_q ? ST_COUNT : ST_DRAIN;
					end else if (fe_q && n_q == 3'd7) begin
						state_n = ST_COUNT;
					end else if (bit_q == 3'd7) begin
						state_n = fe_q ? ST_STAT : ST_DATA;
					end else begin
						state_n = ST_RD;
					end
				end
			end
			ST_STAT: begin
				if (out_ld) begin
					state_n = ST_COUNT;
				end
			end
			ST_DRAIN: begin
				if (acc && frame_end) begin
					state_n = ST_COUNT;
				end
			end
			default: state_n = ST_COUNT;
		endcase
	end

	// control outputs, memory ports, result selection
	always_comb begin
		coded_stall = 1'b1;
		list_we = 1'b0; list_wa = idx_q; list_wd = idx_q; list_ra = '0;
		wt_we = 1'b0; wt_wa = idx_q; wt_wd = full_w; wt_ra = list_rd;
		ch_we = 1'b0; ch_wa = next_q - leaf_cnt_q; ch_ra = walk_q - leaf_cnt_q;
		sy_we = 1'b0; sy_wa = idx_q; sy_wd = coded_byte; sy_ra = nxt;
		emit = 1'b0; e_sym = '0; e_rep = '0; e_last = 1'b0; e_st = 1'b0;
		case (state_q)
			ST_COUNT, ST_TABLEN, ST_DATA, ST_DRAIN: coded_stall = 1'b0;
			ST_ENTRY: begin
				coded_stall = 1'b0;
				if (acc && hpos_q == HPOS_W'(3)) begin
					wt_we = idx_q < NODE_W'(TREE_NODES);
					list_we = (idx_q < NODE_W'(LEAF_MAX)) && !zero_seen_q && (full_w != '0);
				end
				if (acc && hpos_q == HPOS_W'(4)) begin
					sy_we = idx_q < NODE_W'(SYMBOL_COUNT);
				end
			end
			ST_M0: list_ra = len_q - NODE_W'(1);
			ST_M1: list_ra = len_q - NODE_W'(2);
			ST_M3: begin
				wt_we = 1'b1;
				wt_wa = next_q;
				wt_wd = sum_w;
				ch_we = 1'b1;
			end
			ST_S0: list_ra = spos_q - NODE_W'(1);
			ST_S2: begin
				if (wt_rd < w_q) begin
					list_we = 1'b1;
					list_wa = spos_q;
					list_wd = tmp_q;
				end
			end
			ST_INS: begin
				list_we = 1'b1;
				list_wa = spos_q;
				list_wd = next_q;
			end
			ST_ONE: begin
				emit = 1'b1;
				e_sym = sym0_q;
				e_rep = rem_q;
				e_last = 1'b1;
			end
			ST_EMIT: begin
				emit = 1'b1;
				if (rem_q != 32'd0 && fe_q && n_q == 3'd7) begin
					e_st = 1'b1;
				end else begin
					e_sym = sy_rd;
					e_rep = 32'd1;
					e_last = (rem_q == 32'd0);
				end
			end
			ST_STAT: begin
				emit = 1'b1;
				e_st = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa[SIW-1:0]] <= list_wd;
		end
		list_rd <= list_mem[list_ra[SIW-1:0]];
		if (wt_we) begin
			wt_mem[wt_wa[NIW-1:0]] <= wt_wd;
		end
		wt_rd <= wt_mem[wt_ra[NIW-1:0]];
		if (ch_we) begin
			ch_mem[ch_wa[SIW-1:0]] <= {zero_q, one_q};
		end
		ch_rd <= ch_mem[ch_ra[SIW-1:0]];
		if (sy_we) begin
			sy_mem[sy_wa[SIW-1:0]] <= sy_wd;
		end
		// symbol read only on the step, held while the result waits
		if (state_q == ST_NX) begin
			sy_rd <= sy_mem[sy_ra[SIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COUNT;
			hpos_q       <= '0;
			rem_q        <= '0;
			leaf_cnt_q   <= '0;
			walk_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit && out_ld) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_COUNT: begin
					if (acc) begin
						if (frame_end) begin
							hpos_q <= '0;
							rem_q  <= '0;
						end else begin
							rem_q  <= rem_n;
							hpos_q <= (hpos_q == HPOS_W'(3)) ? '0 : hpos_q + HPOS_W'(1);
						end
					end
				end
				ST_TABLEN: begin
					if (acc) begin
						hpos_q     <= '0;
						leaf_cnt_q <= '0;
						if (frame_end) begin
							rem_q <= '0;
						end
					end
				end
				ST_ENTRY: begin
					if (acc) begin
						if (list_we) begin
							leaf_cnt_q <= leaf_cnt_q + NODE_W'(1);
						end
						if (frame_end && !entry_final) begin
							hpos_q <= '0;
							rem_q  <= '0;
						end else begin
							hpos_q <= (hpos_q == HPOS_W'(4)) ? '0 : hpos_q + HPOS_W'(1);
						end
					end
				end
				ST_NX: begin
					if (is_leaf) begin
						rem_q  <= rem_q - 32'd1;
						walk_q <= root_q;
					end else begin
						walk_q <= nxt;
					end
				end
				ST_ONE: begin
					if (out_ld) begin
						rem_q <= '0;
					end
				end
				ST_INS: begin
					if (len_q <= NODE_W'(1)) begin
						walk_q <= next_q;
					end
				end
				ST_STAT: begin
					hpos_q <= '0;
					rem_q  <= '0;
				end
				ST_DRAIN: begin
					if (acc && frame_end) begin
						hpos_q <= '0;
						rem_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit && out_ld) begin
			symbol       <= e_sym;
			repeat_count <= e_rep;
			run_last     <= e_last;
			status       <= e_st;
		end
		case (state_q)
			ST_TABLEN: begin
				total_q     <= NODE_W'(coded_byte) + NODE_W'(1);
				idx_q       <= '0;
				zero_seen_q <= 1'b0;
			end
			ST_ENTRY: begin
				if (acc) begin
					case (hpos_q)
						HPOS_W'(0): wacc_q[7:0]   <= coded_byte;
						HPOS_W'(1): wacc_q[15:8]  <= coded_byte;
						HPOS_W'(2): wacc_q[23:16] <= coded_byte;
						default: ;
					endcase
					if (hpos_q == HPOS_W'(3) && full_w == '0) begin
						zero_seen_q <= 1'b1;
					end
					if (hpos_q == HPOS_W'(4)) begin
						idx_q <= idx_q + NODE_W'(1);
						if (idx_q == '0) begin
							sym0_q <= coded_byte;
						end
					end
					fe_q   <= frame_end;
					len_q  <= leaf_cnt_q;
					next_q <= leaf_cnt_q;
				end
			end
			ST_M1: zero_q <= list_rd;
			ST_M2: begin
				one_q <= list_rd;
				wz_q  <= wt_rd;
			end
			ST_M3: begin
				w_q    <= sum_w;
				len_q  <= len_q - NODE_W'(1);
				spos_q <= len_q - NODE_W'(2);
			end
			ST_S1: tmp_q <= list_rd;
			ST_S2: begin
				if (wt_rd < w_q) begin
					spos_q <= spos_q - NODE_W'(1);
				end
			end
			ST_INS: begin
				next_q <= next_q + NODE_W'(1);
				root_q <= next_q;
			end
			ST_DATA: begin
				if (acc) begin
					byte_q <= coded_byte;
					fe_q   <= frame_end;
					bit_q  <= '0;
					n_q    <= '0;
				end
			end
			ST_NX: begin
				if (!is_leaf) begin
					bit_q <= bit_q + 3'd1;
				end
			end
			ST_EMIT: begin
				if (out_ld) begin
					bit_q <= bit_q + 3'd1;
					n_q   <= n_q + 3'd1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/hbd_checker.sv
// port-level checker for the huffman block decoder, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module hbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [7:0]  symbol,
	input wire logic [31:0] repeat_count,
	input wire logic        run_last,
	input wire logic        status
);

	`HBD_ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(symbol) && $stable(repeat_count) && $stable(status))
	`HBD_ASSERT_NOW(a_status_empty, clk, arst_n, result_valid && status, repeat_count == 32'd0 && !run_last && symbol == 8'd0)
	`HBD_ASSERT_NOW(a_sym_count, clk, arst_n, result_valid && !status, repeat_count != 32'd0)

endmodule

bind huffman_block_decoder_top hbd_checker u_hbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.symbol       (symbol),
	.repeat_count (repeat_count),
	.run_last     (run_last),
	.status       (status)
);
`default_nettype wire

### tb/huffman_block_decoder_top_test.sv
// testbench for the huffman block decoder: frames of header, table and coded data
// are driven byte by byte and every symbol result is checked against a local decoder
// depends on hbd_pkg and huffman_block_decoder_top
`default_nettype none
module huffman_block_decoder_top_test;
	import hbd_pkg::*;

	localparam int NSYM  = DEF_SYMBOL_COUNT;
	localparam int NNODE = DEF_TREE_NODES;

	typedef enum logic [2:0] {P_COUNT, P_TABLEN, P_ENTRY, P_DATA, P_DRAIN} dec_phase_t;

	typedef struct packed {
		logic [7:0]  coded_byte;
		logic        frame_end;
		logic        sync;
	} coded_item_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [31:0] repeat_count;
		logic        run_last;
		logic        status;
	} decoded_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        coded_valid = 0;
	logic        coded_stall;
	logic [7:0]  coded_byte = 0;
	logic        frame_end = 0;
	logic        result_valid;
	logic        result_stall = 0;
	logic [7:0]  symbol;
	logic [31:0] repeat_count;
	logic        run_last;
	logic        status;

	huffman_block_decoder_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.coded_valid(coded_valid), .coded_stall(coded_stall),
		.coded_byte(coded_byte), .frame_end(frame_end),
		.result_valid(result_valid), .result_stall(result_stall),
		.symbol(symbol), .repeat_count(repeat_count),
		.run_last(run_last), .status(status)
	);

	always #4 clk = ~clk;

	coded_item_t pending_bytes[$];
	decoded_t    expected_symbols[$];
	int          errors = 0;
	int          results_seen = 0;

	// decoder state
	dec_phase_t  ph;
	logic [2:0]  hpos;
	logic [31:0] remaining;
	int          leaves;
	int          walk;
	int          tab_total;
	int          entry_idx;
	logic [31:0] weight_mem[NNODE];
	logic [7:0]  sym_mem[NSYM];
	int          zero_child[NSYM];
	int          one_child[NSYM];
	int          order_mem[NSYM];

	function automatic decoded_t mk(logic [7:0] s, logic [31:0] r, logic l, logic st);
		decoded_t d;
		d.symbol = s; d.repeat_count = r; d.run_last = l; d.status = st;
		return d;
	endfunction

	task automatic build_code_tree();
		int lim, i, back, nxt, j, m, z, o, k;
		logic [31:0] w;
		lim = tab_total;
		if (lim > NSYM) lim = NSYM;
		if (lim > (NNODE + 1) / 2) lim = (NNODE + 1) / 2;
		i = 0;
		while (i < lim && weight_mem[i] != 0) begin
			order_mem[i] = i;
			i++;
		end
		leaves = i;
		if (leaves < 2) return;
		back = leaves - 1;
		nxt = leaves;
		while (back > 0) begin
			z = order_mem[back];
			o = order_mem[back - 1];
			back -= 2;
			w = weight_mem[z] + weight_mem[o];
			k = nxt - leaves;
			if (nxt >= NNODE || k >= NSYM) return;
			zero_child[k] = z;
			one_child[k] = o;
			weight_mem[nxt] = w;
			j = back;
			while (j >= 0 && weight_mem[order_mem[j]] < w) j--;
			for (m = back; m >= j + 1; m--) order_mem[m + 1] = order_mem[m];
			order_mem[j + 1] = nxt;
			back++;
			nxt++;
		end
		walk = nxt - 1;
	endtask

	task automatic decode_byte(logic [7:0] b, logic fe);
		decoded_t outs[$];
		int k;
		logic last;
		case (ph)
			P_COUNT: begin
				if (hpos == 0) remaining = 0;
				remaining |= 32'(b) << (8 * hpos[1:0]);
				hpos++;
				if (hpos >= 4) begin
					hpos = 0;
					ph = (remaining == 0) ? P_DRAIN : P_TABLEN;
				end
			end
			P_TABLEN: begin
				tab_total = int'(b) + 1;
				entry_idx = 0;
				hpos = 0;
				ph = P_ENTRY;
			end
			P_ENTRY: begin
				if (entry_idx < NSYM) begin
					if (hpos < 4) begin
						if (hpos == 0) weight_mem[entry_idx] = 0;
						weight_mem[entry_idx] |= 32'(b) << (8 * hpos[1:0]);
					end else begin
						sym_mem[entry_idx] = b;
					end
				end
				hpos++;
				if (hpos >= 5) begin
					hpos = 0;
					entry_idx++;
					if (entry_idx >= tab_total) begin
						build_code_tree();
						if (leaves < 2) begin
							outs.push_back(mk(sym_mem[0], remaining, 1, 0));
							remaining = 0;
							ph = P_DRAIN;
						end else begin
							ph = P_DATA;
						end
					end
				end
			end
			P_DATA: begin
				for (int bi = 0; bi < 8; bi++) begin
					k = walk - leaves;
					if (walk < leaves || k >= NSYM) k = 0;
					walk = b[bi] ? one_child[k] : zero_child[k];
					if (walk < leaves) begin
						remaining--;
						last = (remaining == 0);
						outs.push_back(mk(sym_mem[walk % NSYM], 1, last, 0));
						walk = 2 * leaves - 2;
						if (last) begin
							ph = P_DRAIN;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		if (fe) begin
			if (ph != P_DRAIN) begin
				if (outs.size() >= 8) outs[7] = mk(0, 0, 0, 1);
				else outs.push_back(mk(0, 0, 0, 1));
			end
			ph = P_COUNT;
			hpos = 0;
			remaining = 0;
		end
		foreach (outs[i]) expected_symbols.push_back(outs[i]);
	endtask

	// driver: bursts with random gaps, optional wait for an empty expectation queue
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coded_valid <= 0;
			coded_byte <= 0;
			frame_end <= 0;
			ph = P_COUNT; hpos = 0; remaining = 0; leaves = 0; walk = 0;
			tab_total = 0; entry_idx = 0;
		end else begin
			if (coded_valid && !coded_stall) begin
				decode_byte(coded_byte, frame_end);
				void'(pending_bytes.pop_front());
			end
			if (!(coded_valid && coded_stall)) begin
				if (gap_left > 0) gap_left--;
				if (pending_bytes.size() > 0 && pending_bytes[0].sync
						&& expected_symbols.size() == 0) begin
					pending_bytes[0].sync = 0;
				end
				if (pending_bytes.size() > 0 && !pending_bytes[0].sync && gap_left == 0) begin
					coded_valid <= 1;
					coded_byte <= pending_bytes[0].coded_byte;
					frame_end <= pending_bytes[0].frame_end;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					coded_valid <= 0;
				end
			end
		end
	end

	// monitor and stall pattern
	int cyc = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
		end else begin
			cyc++;
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_symbols.size() == 0) begin
					$error("unexpected result symbol=%0h status=%0b", symbol, status);
					errors++;
				end else begin
					decoded_t e;
					e = expected_symbols.pop_front();
					if (symbol !== e.symbol) begin
						$error("symbol expected %0h actual %0h", e.symbol, symbol); errors++;
					end
					if (repeat_count !== e.repeat_count) begin
						$error("repeat_count expected %0h actual %0h", e.repeat_count,
							repeat_count); errors++;
					end
					if (run_last !== e.run_last) begin
						$error("run_last expected %0b actual %0b", e.run_last, run_last); errors++;
					end
					if (status !== e.status) begin
						$error("status expected %0b actual %0b", e.status, status); errors++;
					end
				end
			end
			if (!hold_done && results_seen >= 60) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1;
			end else begin
				case ((cyc / 97) % 4)
					0: result_stall <= 0;
					1: result_stall <= ($urandom_range(0, 1) == 0);
					2: result_stall <= cyc[0];
					default: result_stall <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	int items_made = 0;

	task automatic put_byte(logic [7:0] b, logic fe, logic sy = 0);
		coded_item_t it;
		it.coded_byte = b; it.frame_end = fe; it.sync = sy;
		pending_bytes.push_back(it);
		items_made++;
	endtask

	task automatic put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], 0);
	endtask

	// frame: weights random unless listed; frame_end on the last byte
	task automatic put_frame(logic [31:0] cnt, int nent, int ndata, int zero_at = -1,
			logic [31:0] w0 = 0, logic [31:0] w1 = 0);
		logic [31:0] w;
		put_word(cnt);
		put_byte(8'(nent - 1), 0);
		for (int i = 0; i < nent; i++) begin
			w = $urandom_range(1, 40);
			if ($urandom_range(0, 9) == 0) w = $urandom | 32'h1;
			if (i == 0 && w0 != 0) w = w0;
			if (i == 1 && w1 != 0) w = w1;
			if (i == zero_at) w = 0;
			put_word(w);
			put_byte(8'($urandom), (ndata == 0) && (i == nent - 1));
		end
		for (int i = 0; i < ndata; i++) put_byte(8'($urandom), i == ndata - 1);
	endtask

	initial begin
		int cnt, nent;
		// two leaves: every bit is a symbol; extreme weights wrap in the sum
		put_word(16); put_byte(1, 0);
		put_word(32'hFFFF_FFFF); put_byte(8'hA5, 0);
		put_word(32'h0000_0001); put_byte(8'h5A, 0);
		put_byte(8'h00, 0); put_byte(8'hFF, 0); put_byte(8'h3C, 1);
		// single symbol table with the largest count
		put_word(32'hFFFF_FFFF); put_byte(0, 0); put_word(7); put_byte(8'hFF, 1);
		// zero count: rest of frame ignored
		put_word(0); put_byte(8'hFF, 0); put_byte(8'h00, 1);
		// frame ends inside the header
		put_byte(8'h12, 0); put_byte(8'h34, 1);
		// early end: the closing byte gives seven symbols and then a status result
		put_word(100); put_byte(1, 0);
		put_word(3); put_byte(8'h01, 0);
		put_word(3); put_byte(8'h02, 0);
		put_byte(8'hFF, 1);
		// first weight zero: no leaves, one result
		put_frame(5, 3, 0, 0);
		// zero weight in the middle cuts the leaf set
		put_frame(12, 5, 3, 3);
		put_byte(0, 0, 1);
		void'(pending_bytes.pop_back());
		items_made--;
		pending_bytes[pending_bytes.size() - 1].sync = 0;
		// wait for all earlier results before the last count byte of this frame
		put_frame(4, 3, 2);
		pending_bytes[pending_bytes.size() - 3 - 5 * 3 - 2 + 1].sync = 1;

		while (items_made < 200) begin
			case ($urandom_range(0, 19))
				0: begin
					// frame cut short in the header or table
					for (int i = $urandom_range(0, 5); i > 0; i--) put_byte(8'($urandom), 0);
					put_byte(8'($urandom), 1);
				end
				1: put_frame($urandom_range(1, 3), 1, $urandom_range(0, 2));
				2: put_frame(0, 1, 1);
				default: begin
					nent = $urandom_range(2, 6);
					cnt = $urandom_range(1, 24);
					put_frame(cnt, nent, $urandom_range(1, 5),
						($urandom_range(0, 9) == 0) ? $urandom_range(1, nent - 1) : -1);
				end
			endcase
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (4) @(posedge clk);
		wait (pending_bytes.size() == 0);
		wait (expected_symbols.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_symbols.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

### huffman_block_decoder_top.f
+incdir+hw/rtl
hw/rtl/hbd_pkg.sv
hw/rtl/huffman_block_decoder_top.sv
hw/rtl/hbd_checker.sv
tb/huffman_block_decoder_top_test.sv
